### hdl/macp_pkg.sv
// ----------------------------------------------------------------------------
// macp_pkg
// shared types and constants of the address text parser
// ----------------------------------------------------------------------------
package macp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned IDX_W  = 3;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;

    typedef enum logic [STAT_W-1:0] {
        ST_OK            = 3'd0,
        ST_OUT_OF_RANGE  = 3'd1,
        ST_MISSING_FIELD = 3'd2,
        ST_INVALID_CHAR  = 3'd3,
        ST_INVALID_SEP   = 3'd4,
        ST_EXCESS        = 3'd5
    } status_t;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_colon;
        logic       is_dash;
        logic       is_nul;
    } char_class_t;

endpackage

### hdl/macp_classify.sv
// ----------------------------------------------------------------------------
// macp_classify
// sorts one text character into hex digit, separator or terminator
// ----------------------------------------------------------------------------
module macp_classify (
    input  logic [macp_pkg::CHAR_W-1:0] char_in,
    output macp_pkg::char_class_t       cls
);

    logic [macp_pkg::CHAR_W-1:0] off_num;
    logic [macp_pkg::CHAR_W-1:0] off_lo;
    logic [macp_pkg::CHAR_W-1:0] off_up;

    always_comb begin
        off_num = char_in - 8'h30;
        off_lo  = char_in - 8'h61;
        off_up  = char_in - 8'h41;
        cls          = '0;
        cls.is_colon = (char_in == macp_pkg::CHAR_COLON);
        cls.is_dash  = (char_in == macp_pkg::CHAR_DASH);
        cls.is_nul   = (char_in == macp_pkg::CHAR_NUL);
        if (char_in >= 8'h30 && char_in <= 8'h39) begin
            cls.is_digit = 1'b1;
            cls.digit    = off_num[3:0];
        end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
            cls.is_digit = 1'b1;
            cls.digit    = 4'd10 + off_lo[3:0];
        end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
            cls.is_digit = 1'b1;
            cls.digit    = 4'd10 + off_up[3:0];
        end
    end

endmodule

### hdl/macp_parser.sv
// ----------------------------------------------------------------------------
// macp_parser
// field and separator state, error detection and the result register
// ----------------------------------------------------------------------------
module macp_parser #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          item_fire,
    input  macp_pkg::char_class_t         cls,
    output logic                          res_valid,
    output macp_pkg::status_t             res_status,
    output logic [macp_pkg::ADDR_W-1:0]   res_address
);

    localparam logic [macp_pkg::IDX_W-1:0] LAST_FIELD = macp_pkg::IDX_W'(FIELD_COUNT - 1);

    logic [macp_pkg::IDX_W-1:0]  field_index_reg, field_index_next;
    logic [7:0]                  field_value_reg, field_value_next;
    logic                        digit_seen_reg, digit_seen_next;
    logic                        dash_sep_reg, dash_sep_next;
    logic [macp_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        discard_reg, discard_next;
    logic                        res_valid_reg;
    macp_pkg::status_t           status_reg;
    logic [macp_pkg::ADDR_W-1:0] address_reg;

    logic                        emit;
    macp_pkg::status_t           emit_status;
    logic [macp_pkg::ADDR_W-1:0] addr_shift;

    always_comb begin
        field_index_next = field_index_reg;
        field_value_next = field_value_reg;
        digit_seen_next  = digit_seen_reg;
        dash_sep_next    = dash_sep_reg;
        addr_next        = addr_reg;
        discard_next     = discard_reg;
        emit             = 1'b0;
        emit_status      = macp_pkg::ST_OK;
        addr_shift       = {addr_reg[macp_pkg::ADDR_W-9:0], field_value_reg};

        if (discard_reg) begin
            if (cls.is_nul) begin
                discard_next = 1'b0;
            end
        end else if (cls.is_digit) begin
            if (field_value_reg[7:4] != 4'd0) begin
                emit        = 1'b1;
                emit_status = macp_pkg::ST_OUT_OF_RANGE;
            end else begin
                field_value_next = {field_value_reg[3:0], cls.digit};
                digit_seen_next  = 1'b1;
            end
        end else if (!digit_seen_reg) begin
            emit        = 1'b1;
            emit_status = macp_pkg::ST_MISSING_FIELD;
        end else if (field_index_reg == '0) begin
            if (cls.is_colon) begin
                dash_sep_next = 1'b0;
            end else if (cls.is_dash) begin
                dash_sep_next = 1'b1;
            end else begin
                emit        = 1'b1;
                emit_status = macp_pkg::ST_INVALID_CHAR;
            end
        end else if (field_index_reg < LAST_FIELD) begin
            if (dash_sep_reg ? !cls.is_dash : !cls.is_colon) begin
                emit        = 1'b1;
                emit_status = macp_pkg::ST_INVALID_SEP;
            end
        end else begin
            emit        = 1'b1;
            emit_status = cls.is_nul ? macp_pkg::ST_OK : macp_pkg::ST_EXCESS;
        end

        // field closed by a good separator
        if (!discard_reg && !cls.is_digit && !emit) begin
            addr_next        = addr_shift;
            field_index_next = field_index_reg + 1'b1;
            field_value_next = '0;
            digit_seen_next  = 1'b0;
        end

        if (emit) begin
            field_index_next = '0;
            field_value_next = '0;
            digit_seen_next  = 1'b0;
            dash_sep_next    = 1'b0;
            addr_next        = '0;
            discard_next     = !cls.is_nul;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg <= '0;
            field_value_reg <= '0;
            digit_seen_reg  <= 1'b0;
            dash_sep_reg    <= 1'b0;
            addr_reg        <= '0;
            discard_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= item_fire && emit;
            if (item_fire) begin
                field_index_reg <= field_index_next;
                field_value_reg <= field_value_next;
                digit_seen_reg  <= digit_seen_next;
                dash_sep_reg    <= dash_sep_next;
                addr_reg        <= addr_next;
                discard_reg     <= discard_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_fire && emit) begin
            status_reg  <= emit_status;
            address_reg <= (emit_status == macp_pkg::ST_OK) ? addr_shift : '0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_status  = status_reg;
    assign res_address = address_reg;

endmodule

### hdl/mac_address_text_parser_top.sv
// ----------------------------------------------------------------------------
// mac_address_text_parser_top
// streaming parser of hardware address text into a 48-bit address
// ----------------------------------------------------------------------------
// One character is taken per beat and a new beat can be accepted every clock
// cycle unless the result side stalls; a zero character ends a string. Each
// character passes an input register and then the parse step, which updates
// the field state and loads the result register. A string gives one result:
// status ok with the address on its terminator, or the first error at the
// offending character, after which characters are dropped up to the next
// terminator. Backpressure on the result side stalls both registers together.
module mac_address_text_parser_top #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // character
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status [2:0], address [50:3], zero pad
);

    logic                        in_valid_reg;
    logic [macp_pkg::CHAR_W-1:0] in_char_reg;
    logic                        advance;
    logic                        item_fire;
    macp_pkg::char_class_t       cls;
    logic                        res_valid;
    macp_pkg::status_t           res_status;
    logic [macp_pkg::ADDR_W-1:0] res_address;

    assign advance   = !res_valid || m_tready;
    assign item_fire = in_valid_reg;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
        end
    end

    macp_classify u_classify (
        .char_in (in_char_reg),
        .cls     (cls)
    );

    macp_parser #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item_fire   (item_fire),
        .cls         (cls),
        .res_valid   (res_valid),
        .res_status  (res_status),
        .res_address (res_address)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {5'd0, res_address, res_status};

    // an error result never carries an address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != macp_pkg::ST_OK) |-> (m_tdata[50:3] == '0))
        else $error("error result with nonzero address");

    // status code stays within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= macp_pkg::ST_EXCESS))
        else $error("undefined status code");

    // an empty result register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    // a stalled result keeps the pipeline frozen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input accepted while pipeline stalled");

endmodule
